@@ rtl/bpp_pkg.sv @@
// Package for the binary projection profile block.
// Holds the item and result structs, the configuration register indexes and reset values.
// No dependencies.
package bpp_pkg;

  localparam int COUNT_W    = 11;
  localparam int POS_W      = 10;
  localparam int PIXEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Item and result kinds.
  localparam logic KIND_PIXEL       = 1'b0;
  localparam logic KIND_COLUMN_READ = 1'b1;
  localparam logic RESULT_ROW       = 1'b0;
  localparam logic RESULT_COLUMN    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd2;

  localparam logic [PIXEL_W-1:0] THRESHOLD_RESET     = 8'd50;
  localparam logic [COUNT_W-1:0] ACTIVE_WIDTH_RESET  = 11'd640;
  localparam logic [COUNT_W-1:0] ACTIVE_HEIGHT_RESET = 11'd480;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel_value;
    logic [POS_W-1:0]   column_select;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               frame_done;
  } result_t;

endpackage

@@ rtl/binary_projection_profile_core.sv @@
// Top level of the binary projection profile block: row and column target counts of a pixel stream.
// Depends on bpp_pkg.
//
// Pixels arrive in raster order and each one whose value exceeds the threshold counts as a
// target. The block emits the row's target count after the last pixel of every row, flags the
// last row of a frame, and answers column read items with the count held for that column in a
// single-port-per-direction column memory. The sustained rate is one item per clock while the
// result output is not stalled. Each item passes a read stage, in which the column memory is read,
// and a write-back stage that writes back the new count and forms the result, then the output register.
// Back-to-back pixels in the same column (a one-pixel-wide row) or a column read straight after
// the pixel that updates that column are served by forwarding the value being written.
// Column entries hold no defined value until the first row of a frame has written them.
module binary_projection_profile_core
  import bpp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CMP_W = 14;

  // Configuration registers.
  logic [PIXEL_W-1:0] threshold;
  logic [COUNT_W-1:0] active_width;
  logic [COUNT_W-1:0] active_height;

  // Raster position and running row count.
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic [COUNT_W-1:0] row_count;

  // Column memory.
  logic [COUNT_W-1:0] col_mem [MAX_WIDTH];
  logic [COUNT_W-1:0] rd_data;

  // Write-back stage.
  logic               s1_valid;
  logic               s1_kind;
  logic               s1_hit;
  logic               s1_first;
  logic               s1_in_range;
  logic               s1_emit;
  logic [COL_W-1:0]   s1_addr;
  logic [POS_W-1:0]   s1_pos;
  logic [COUNT_W-1:0] s1_row_count;
  logic               s1_frame_done;
  logic               s1_fwd;
  logic [COUNT_W-1:0] s1_fwd_data;

  logic               item_accept;
  logic               s1_advance;
  logic               hit;
  logic               last_col;
  logic               last_row;
  logic               in_range;
  logic [COL_W-1:0]   rd_addr;
  logic [COUNT_W-1:0] row_sum;
  logic [COUNT_W-1:0] mem_val;
  logic [COUNT_W-1:0] col_new;
  logic               wr_en;
  result_t            s1_result;

  assign cfg_ready   = 1'b1;
  assign item_accept = item_valid && item_ready;
  assign s1_advance  = !s1_emit || !result_valid || result_ready;
  assign item_ready  = !s1_valid || s1_advance;

  always_comb begin
    hit      = item.pixel_value > threshold;
    row_sum  = (row_count == COUNT_MAX) ? row_count : row_count + COUNT_W'(hit);
    // Width and height above the memory size clamp to it; zero behaves as one.
    last_col = (CMP_W'(col_pos) + CMP_W'(1) >= CMP_W'(active_width)) ||
               (col_pos == COL_W'(MAX_WIDTH - 1));
    last_row = (CMP_W'(row_pos) + CMP_W'(1) >= CMP_W'(active_height)) ||
               (row_pos == ROW_W'(MAX_HEIGHT - 1));
    in_range = CMP_W'(item.column_select) < CMP_W'(MAX_WIDTH);
    rd_addr  = (item.kind == KIND_PIXEL) ? col_pos : COL_W'(item.column_select);
  end

  always_comb begin
    mem_val = s1_fwd ? s1_fwd_data : rd_data;
    if (s1_first) begin
      col_new = COUNT_W'(s1_hit);
    end else if (mem_val == COUNT_MAX) begin
      col_new = mem_val;
    end else begin
      col_new = mem_val + COUNT_W'(s1_hit);
    end
    wr_en = s1_valid && s1_advance && (s1_kind == KIND_PIXEL);
    s1_result.result_kind = s1_kind;
    s1_result.position    = s1_pos;
    if (s1_kind == KIND_COLUMN_READ) begin
      s1_result.count      = s1_in_range ? mem_val : '0;
      s1_result.frame_done = 1'b0;
    end else begin
      s1_result.count      = s1_row_count;
      s1_result.frame_done = s1_frame_done;
    end
  end

  // Read-first memory: a write and a read of the same entry at one edge return the old value,
  // so the value being written is captured for the following stage.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      rd_data     <= col_mem[rd_addr];
      s1_kind     <= item.kind;
      s1_hit      <= hit;
      s1_first    <= (row_pos == '0);
      s1_addr     <= rd_addr;
      s1_in_range <= (item.kind == KIND_PIXEL) || in_range;
      s1_fwd      <= wr_en && (s1_addr == rd_addr);
      s1_fwd_data <= col_new;
      s1_row_count  <= row_sum;
      s1_frame_done <= last_row;
      s1_pos <= (item.kind == KIND_PIXEL) ? POS_W'(row_pos) : item.column_select;
    end
    if (wr_en) begin
      col_mem[s1_addr] <= col_new;
    end
    if (s1_valid && s1_advance && s1_emit) begin
      result <= s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RESET;
      active_width  <= ACTIVE_WIDTH_RESET;
      active_height <= ACTIVE_HEIGHT_RESET;
      col_pos       <= '0;
      row_pos       <= '0;
      row_count     <= '0;
      s1_valid      <= 1'b0;
      s1_emit       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_THRESHOLD:     threshold     <= cfg_data[PIXEL_W-1:0];
          CFG_ACTIVE_WIDTH:  active_width  <= cfg_data;
          CFG_ACTIVE_HEIGHT: active_height <= cfg_data;
          default: ;
        endcase
      end

      if (item_accept && item.kind == KIND_PIXEL) begin
        if (last_col) begin
          col_pos   <= '0;
          row_count <= '0;
          row_pos   <= last_row ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos   <= col_pos + COL_W'(1);
          row_count <= row_sum;
        end
      end

      if (item_accept) begin
        s1_valid <= 1'b1;
        s1_emit  <= (item.kind == KIND_COLUMN_READ) || last_col;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
        s1_emit  <= 1'b0;
      end

      if (s1_valid && s1_advance && s1_emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/bpp_checker.sv @@
// Port-level checks for the binary projection profile block, bound to its top level.
// Depends on bpp_pkg and binary_projection_profile_core.
module bpp_checker
  import bpp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // Nothing is offered straight after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Column read answers never close a frame.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RESULT_COLUMN |-> !result.frame_done)
    else $error("column read flagged as frame end");

  // A row never holds more pixels than the column memory has entries.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RESULT_ROW
      |-> 32'(result.count) <= 32'(MAX_WIDTH))
    else $error("row count exceeds row length");

endmodule

bind binary_projection_profile_core bpp_checker #(.MAX_WIDTH(MAX_WIDTH)) u_bpp_checker (.*);
